FILE: hw/rtl/rap_pkg.sv
package rap_pkg;

  // message layout
  localparam logic [7:0] RA_TYPE      = 8'd134;
  localparam logic [7:0] OPT_PREFIX   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd25;
  localparam int         HEADER_BYTES = 16;

  // option walk widths
  localparam int OFF_W = 11;

  // default message size limit
  localparam int MAX_MSG_BYTES_DEFAULT = 2048;

  // result codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_FLAG_MISS = 3'd1;
  localparam logic [2:0] STATUS_NOT_RA    = 3'd2;
  localparam logic [2:0] STATUS_ZERO_LEN  = 3'd3;
  localparam logic [2:0] STATUS_TRUNC     = 3'd4;

  // configuration register indexes
  localparam int         CFG_INDEX_W   = 2;
  localparam logic [1:0] CFG_LLA_HIGH  = 2'd0;
  localparam logic [1:0] CFG_LLA_LOW   = 2'd1;
  localparam logic [1:0] CFG_WANTED_MO = 2'd2;

  localparam int OUT_DATA_W = 352;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } rap_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  mo_flags;
    logic [15:0] lifetime_s;
    logic [31:0] reach_ms;
    logic [31:0] retx_ms;
    logic [7:0]  prefix_length;
    logic [63:0] global_high;
    logic [63:0] global_low;
    logic        prefix_seen;
    logic [63:0] dns_high;
    logic [63:0] dns_low;
    logic        dns_seen;
  } rap_result_t;

endpackage

FILE: hw/rtl/rap_beat_reg.sv
module rap_beat_reg #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  T     up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output T     dn_data
);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= up_data;
    end
  end

endmodule

FILE: hw/rtl/rap_parse_core.sv
module rap_parse_core #(
  parameter int MAX_MESSAGE_BYTES = rap_pkg::MAX_MSG_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  rap_pkg::rap_in_t    item,
  input  logic [63:0]         lla_high,
  input  logic [63:0]         lla_low,
  input  logic [1:0]          wanted_mo,
  output rap_pkg::rap_result_t result
);
  import rap_pkg::*;

  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(HEADER_BYTES);

  logic [POS_W-1:0]      byte_position, byte_position_next;
  logic [7:0]            option_kind, option_kind_next;
  logic [OFF_W-1:0]      option_total, option_total_next;
  logic [OFF_W-1:0]      option_offset, option_offset_next;
  logic [7:0]            flag_byte, flag_byte_next;
  logic [15:0]           lifetime_reg, lifetime_reg_next;
  logic [31:0]           reachable_reg, reachable_reg_next;
  logic [31:0]           retrans_reg, retrans_reg_next;
  logic [7:0]            prefix_bits, prefix_bits_next;
  logic [15:0][7:0]      merged, merged_next;
  logic [127:0]          dns_addr, dns_addr_next;
  logic                  prefix_seen, prefix_seen_next;
  logic                  dns_seen, dns_seen_next;
  logic [2:0]            error_code, error_code_next;

  always_comb begin
    logic [7:0]   b;
    logic [OFF_W:0] off_inc;
    logic [4:0]   n_bytes;
    logic [3:0]   idx;
    logic [2:0]   st;
    logic [1:0]   mo;

    b       = item.data_byte;
    off_inc = {1'b0, option_offset} + 1'b1;
    n_bytes = (prefix_bits[7:3] > 5'd16) ? 5'd16 : prefix_bits[7:3];
    idx     = option_offset[3:0];

    byte_position_next = byte_position;
    option_kind_next   = option_kind;
    option_total_next  = option_total;
    option_offset_next = option_offset;
    flag_byte_next     = flag_byte;
    lifetime_reg_next  = lifetime_reg;
    reachable_reg_next = reachable_reg;
    retrans_reg_next   = retrans_reg;
    prefix_bits_next   = prefix_bits;
    // a fresh message starts from the current link-local address
    merged_next        = (byte_position == '0) ? {lla_high, lla_low} : merged;
    dns_addr_next      = dns_addr;
    prefix_seen_next   = prefix_seen;
    dns_seen_next      = dns_seen;
    error_code_next    = error_code;

    if (byte_position < POS_MAX && error_code == STATUS_OK) begin
      if (byte_position == '0) begin
        if (b != RA_TYPE) error_code_next = STATUS_NOT_RA;
      end else if (byte_position == POS_W'(5)) begin
        flag_byte_next = b;
      end else if (byte_position == POS_W'(6) || byte_position == POS_W'(7)) begin
        lifetime_reg_next = {lifetime_reg[7:0], b};
      end else if (byte_position >= POS_W'(8) && byte_position < POS_W'(12)) begin
        reachable_reg_next = {reachable_reg[23:0], b};
      end else if (byte_position >= POS_W'(12) && byte_position < POS_HDR) begin
        retrans_reg_next = {retrans_reg[23:0], b};
      end else if (byte_position >= POS_HDR) begin
        // option walk
        if (option_offset == '0) begin
          option_kind_next   = b;
          option_offset_next = OFF_W'(1);
        end else if (option_offset == OFF_W'(1)) begin
          if (b == 8'd0) begin
            error_code_next    = STATUS_ZERO_LEN;
            option_offset_next = '0;
          end else begin
            option_total_next  = {b, 3'b000};
            option_offset_next = OFF_W'(2);
          end
        end else begin
          if (option_kind == OPT_PREFIX) begin
            if (option_offset == OFF_W'(2)) begin
              prefix_bits_next = b;
              merged_next      = {lla_high, lla_low};
              prefix_seen_next = 1'b1;
            end else if (option_offset >= OFF_W'(16) && option_offset < OFF_W'(32)) begin
              if ({1'b0, idx} < n_bytes) merged_next[~idx] = b;
            end
          end else if (option_kind == OPT_DNS) begin
            if (option_offset >= OFF_W'(8) && option_offset < OFF_W'(24)) begin
              if (option_offset == OFF_W'(8)) begin
                dns_addr_next = {120'd0, b};
                dns_seen_next = 1'b1;
              end else begin
                dns_addr_next = {dns_addr[119:0], b};
              end
            end
          end
          option_offset_next = (off_inc >= {1'b0, option_total}) ? '0 : off_inc[OFF_W-1:0];
        end
      end
    end
    if (byte_position < POS_MAX) byte_position_next = byte_position + 1'b1;

    mo = flag_byte_next[7:6];
    st = error_code_next;
    if (st == STATUS_OK && (byte_position_next < POS_HDR || option_offset_next != '0))
      st = STATUS_TRUNC;
    if (st == STATUS_OK && mo != wanted_mo) st = STATUS_FLAG_MISS;

    result.status          = st;
    result.mo_flags        = mo;
    result.lifetime_s      = lifetime_reg_next;
    result.reach_ms        = reachable_reg_next;
    result.retx_ms         = retrans_reg_next;
    result.prefix_length   = prefix_bits_next;
    result.global_high     = merged_next[15:8];
    result.global_low      = merged_next[7:0];
    result.prefix_seen     = prefix_seen_next;
    result.dns_high        = dns_addr_next[127:64];
    result.dns_low         = dns_addr_next[63:0];
    result.dns_seen        = dns_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      byte_position <= '0;
      option_kind   <= '0;
      option_total  <= '0;
      option_offset <= '0;
      flag_byte     <= '0;
      lifetime_reg  <= '0;
      reachable_reg <= '0;
      retrans_reg   <= '0;
      prefix_bits   <= '0;
      dns_addr      <= '0;
      prefix_seen   <= 1'b0;
      dns_seen      <= 1'b0;
      error_code    <= STATUS_OK;
    end else if (step) begin
      byte_position <= byte_position_next;
      option_kind   <= option_kind_next;
      option_total  <= option_total_next;
      option_offset <= option_offset_next;
      flag_byte     <= flag_byte_next;
      lifetime_reg  <= lifetime_reg_next;
      reachable_reg <= reachable_reg_next;
      retrans_reg   <= retrans_reg_next;
      prefix_bits   <= prefix_bits_next;
      dns_addr      <= dns_addr_next;
      prefix_seen   <= prefix_seen_next;
      dns_seen      <= dns_seen_next;
      error_code    <= error_code_next;
    end
  end

  // merged address is only read while a message is open
  always_ff @(posedge clk) begin
    if (step) merged <= merged_next;
  end

endmodule

FILE: hw/rtl/router_advert_parser.sv
// router advertisement parser: takes one icmpv6 router advertisement a byte
// per beat on the s_ side (type byte first, s_tlast on the final byte) and
// gives one result beat on the m_ side per message. the header fields (m/o
// flags, router lifetime, reachable and retransmit times) are captured, then
// options are walked by their length; a prefix-information option overwrites
// the leading min(prefix length/8, 16) bytes of the configured link-local
// address (last one wins), and a recursive dns server option yields its first
// address. status is 0 accepted, 1 m/o flags differ from wanted_mo, 2 not a
// router advertisement, 3 zero-length option, 4 message ended early. a byte
// is taken every cycle; one input register and one result register sit around
// the per-byte logic, and a result beat leaves from the result register;
// the input side stalls only when a last byte meets a held result.
// bytes beyond MAX_MESSAGE_BYTES are dropped. configuration registers
// (0 lla_high, 1 lla_low, 2 wanted_mo) are written through the cfg_ port,
// which is always ready; writes to other indexes are ignored.
module router_advert_parser #(
  parameter int MAX_MESSAGE_BYTES = rap_pkg::MAX_MSG_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // input bytes
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte
  input  logic                            s_tlast,   // last_byte
  // results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, mo_flags, lifetime_s, reach_ms, retx_ms,
  // prefix_length, global_high, global_low, prefix_seen, dns_high,
  // dns_low, dns_seen, one zero pad bit on top
  output logic [rap_pkg::OUT_DATA_W-1:0]  m_tdata,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);
  import rap_pkg::*;

  logic [63:0] lla_high;
  logic [63:0] lla_low;
  logic [1:0]  wanted_mo;

  rap_in_t     s_item;
  rap_in_t     in_item;
  logic        in_valid;
  logic        in_go;       // held byte may move through the core this cycle
  logic        core_step;
  logic        out_up_ready;
  rap_result_t core_result;
  rap_result_t out_result;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lla_high  <= '0;
      lla_low   <= '0;
      wanted_mo <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LLA_HIGH:  lla_high  <= cfg_data;
        CFG_LLA_LOW:   lla_low   <= cfg_data;
        CFG_WANTED_MO: wanted_mo <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign s_item.data_byte = s_tdata;
  assign s_item.last_byte = s_tlast;

  // input register
  rap_beat_reg #(.T(rap_in_t)) u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s_tvalid),
    .up_ready (s_tready),
    .up_data  (s_item),
    .dn_valid (in_valid),
    .dn_ready (in_go),
    .dn_data  (in_item)
  );

  // only a last byte needs room in the result register
  assign in_go     = !in_item.last_byte || out_up_ready;
  assign core_step = in_valid && in_go;

  rap_parse_core #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (core_step),
    .item      (in_item),
    .lla_high  (lla_high),
    .lla_low   (lla_low),
    .wanted_mo (wanted_mo),
    .result    (core_result)
  );

  // result register
  rap_beat_reg #(.T(rap_result_t)) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid && in_item.last_byte),
    .up_ready (out_up_ready),
    .up_data  (core_result),
    .dn_valid (m_tvalid),
    .dn_ready (m_tready),
    .dn_data  (out_result)
  );

  // pack with status in the lowest bits
  assign m_tdata = {1'b0,
                    out_result.dns_seen,
                    out_result.dns_low,
                    out_result.dns_high,
                    out_result.prefix_seen,
                    out_result.global_low,
                    out_result.global_high,
                    out_result.prefix_length,
                    out_result.retx_ms,
                    out_result.reach_ms,
                    out_result.lifetime_s,
                    out_result.mo_flags,
                    out_result.status};

endmodule
